>>> rtl/core/dpb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the depth pixel back-projection block.
// Used by dpb_lateral and depth_pixel_backprojection; depends on nothing.
package dpb_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int NUM_STAGES         = 6;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam int DEPTH_BITS = 16;
   localparam int COLOR_BITS = 24;
   localparam int INV_BITS   = 32;
   localparam int CENTER_BITS = 16;
   localparam int Z_BITS     = 31;
   localparam int POINT_BITS = 32;

   localparam logic [31:0] INV_DEPTH_SCALE_RESET = 32'd16777;
   localparam logic [31:0] INV_FOCAL_X_RESET     = 32'd8181081;
   localparam logic [31:0] INV_FOCAL_Y_RESET     = 32'd8181081;
   localparam logic [15:0] CENTER_X_RESET        = 16'd5112;
   localparam logic [15:0] CENTER_Y_RESET        = 16'd3832;

   localparam logic [30:0] Z_MAX = 31'h7FFF_FFFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INV_DEPTH_SCALE = 3'd0,
      CSR_INV_FOCAL_X     = 3'd1,
      CSR_INV_FOCAL_Y     = 3'd2,
      CSR_CENTER_X        = 3'd3,
      CSR_CENTER_Y        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic ld_s1;
      logic ld_s2;
      logic ld_s3;
      logic ld_s4;
      logic ld_s5;
      logic ld_s6;
   } stage_load_type;

endpackage

>>> rtl/core/dpb_lateral.sv
`timescale 1ns / 1ps
// One lateral coordinate lane: offset, scale by z, scale by reciprocal focal length,
// round half away from zero and saturate to Q16.16. Depends on dpb_pkg.
module dpb_lateral #(
   parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  dpb_pkg::stage_load_type     load,
   input  logic [COORD_BITS-1:0]       coord,
   input  logic [dpb_pkg::CENTER_BITS-1:0] center,
   input  logic [dpb_pkg::INV_BITS-1:0]    inv_f,
   input  logic [dpb_pkg::Z_BITS-1:0]      zq,
   output logic signed [dpb_pkg::POINT_BITS-1:0] point
);
   import dpb_pkg::*;

   localparam int CW  = COORD_BITS + 4;
   localparam int DW  = (CW > CENTER_BITS) ? CW : CENTER_BITS;
   localparam int MPW = DW + Z_BITS;
   localparam int HW  = MPW - 32;
   localparam int HPW = HW + INV_BITS;
   localparam int AW  = HPW + 1;
   localparam int RW  = AW + 1;
   localparam int GW  = AW - 3;

   logic          neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [DW-1:0] mag1_ff, mag2_ff;
   logic [MPW-1:0] m3_ff;
   logic [63:0]   lo4_ff;
   logic [HPW-1:0] hi4_ff;
   logic [AW-1:0] a5_ff;
   logic [POINT_BITS-1:0] point_ff;

   logic [DW-1:0] c16_w;
   logic [DW-1:0] ctr_w;
   logic          neg1_in;
   logic [DW-1:0] mag1_in;
   logic [MPW-1:0] m3_in;
   logic [63:0]   lo4_in;
   logic [HPW-1:0] hi4_in;
   logic [AW-1:0] a5_in;
   logic [RW-1:0] rnd_w;
   logic [GW-1:0] mag_w;
   logic [GW-1:0] lim_w;
   logic [GW-1:0] sat_w;
   logic [POINT_BITS-1:0] point_in;

   always_comb begin
      c16_w   = DW'({coord, 4'b0000});
      ctr_w   = DW'(center);
      neg1_in = c16_w < ctr_w;
      mag1_in = neg1_in ? (ctr_w - c16_w) : (c16_w - ctr_w);

      m3_in  = MPW'(mag2_ff) * MPW'(zq);

      lo4_in = 64'(m3_ff[31:0]) * 64'(inv_f);
      hi4_in = HPW'(m3_ff[MPW-1:32]) * HPW'(inv_f);

      a5_in  = AW'(hi4_ff) + AW'(lo4_ff[63:32]);

      rnd_w  = RW'(a5_ff) + RW'(8);
      mag_w  = rnd_w[RW-1:4];
      lim_w  = neg5_ff ? GW'(33'h1_0000_0000 >> 1) : GW'(32'h7FFF_FFFF);
      sat_w  = (mag_w > lim_w) ? lim_w : mag_w;
      point_in = neg5_ff ? (32'd0 - sat_w[31:0]) : sat_w[31:0];
   end

   always_ff @(posedge clock) begin
      if (load.ld_s1) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (load.ld_s2) begin
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
      end
      if (load.ld_s3) begin
         neg3_ff <= neg2_ff;
         m3_ff   <= m3_in;
      end
      if (load.ld_s4) begin
         neg4_ff <= neg3_ff;
         lo4_ff  <= lo4_in;
         hi4_ff  <= hi4_in;
      end
      if (load.ld_s5) begin
         neg5_ff <= neg4_ff;
         a5_ff   <= a5_in;
      end
      if (load.ld_s6) begin
         point_ff <= point_in;
      end
   end

   assign point = signed'(point_ff);

endmodule

>>> rtl/core/depth_pixel_backprojection.sv
`timescale 1ns / 1ps
// An accepted pixel moves through stage registers s1 to s6 in order; rsp_valid is the valid bit of s6.
// Throughput: one pixel per cycle while rsp_stall is low, set by the six-stage multiply pipeline;
// a stall on the result side backs up only as far as the first empty stage.
// Pixels with zero depth are accepted and dropped.
// Reset: synchronous; clears all stage valid bits and loads register defaults.
module depth_pixel_backprojection #(
   parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   input  logic                                 csr_write,
   input  logic [dpb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dpb_pkg::CSR_DATA_BITS-1:0]    csr_data,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [COORD_BITS-1:0]                req_col,
   input  logic [COORD_BITS-1:0]                req_row,
   input  logic [dpb_pkg::DEPTH_BITS-1:0]       req_depth,
   input  logic [dpb_pkg::COLOR_BITS-1:0]       req_color_bgr,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dpb_pkg::POINT_BITS-1:0] rsp_point_x,
   output logic signed [dpb_pkg::POINT_BITS-1:0] rsp_point_y,
   output logic [dpb_pkg::Z_BITS-1:0]           rsp_point_z,
   output logic [dpb_pkg::COLOR_BITS-1:0]       rsp_point_color
);
   import dpb_pkg::*;

   localparam int PW = DEPTH_BITS + INV_BITS;
   localparam int ZRW = PW + 1;

   logic [INV_BITS-1:0]    inv_depth_scale_ff;
   logic [INV_BITS-1:0]    inv_focal_x_ff;
   logic [INV_BITS-1:0]    inv_focal_y_ff;
   logic [CENTER_BITS-1:0] center_x_ff;
   logic [CENTER_BITS-1:0] center_y_ff;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;
   stage_load_type        load;

   logic [PW-1:0]         p1_ff;
   logic [PW-1:0]         p1_in;
   logic [Z_BITS-1:0]     z2_ff, z3_ff, z4_ff, z5_ff, z6_ff;
   logic [Z_BITS-1:0]     z2_in;
   logic [ZRW-1:0]        zr_w;
   logic [COLOR_BITS-1:0] color1_ff, color2_ff, color3_ff, color4_ff, color5_ff, color6_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_depth_scale_ff <= INV_DEPTH_SCALE_RESET;
         inv_focal_x_ff     <= INV_FOCAL_X_RESET;
         inv_focal_y_ff     <= INV_FOCAL_Y_RESET;
         center_x_ff        <= CENTER_X_RESET;
         center_y_ff        <= CENTER_Y_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_DEPTH_SCALE: inv_depth_scale_ff <= csr_data[INV_BITS-1:0];
            CSR_INV_FOCAL_X:     inv_focal_x_ff     <= csr_data[INV_BITS-1:0];
            CSR_INV_FOCAL_Y:     inv_focal_y_ff     <= csr_data[INV_BITS-1:0];
            CSR_CENTER_X:        center_x_ff        <= csr_data[CENTER_BITS-1:0];
            CSR_CENTER_Y:        center_y_ff        <= csr_data[CENTER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // stage flow control: a stage loads when empty or when the next one advances
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? (req_valid && (req_depth != '0)) : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
      load.ld_s1 = ready[0];
      load.ld_s2 = ready[1];
      load.ld_s3 = ready[2];
      load.ld_s4 = ready[3];
      load.ld_s5 = ready[4];
      load.ld_s6 = ready[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // depth scaling, then round to unsigned Q15.16 and saturate
   always_comb begin
      p1_in = PW'(req_depth) * PW'(inv_depth_scale_ff);
      zr_w  = (ZRW'(p1_ff) + ZRW'(128)) >> 8;
      z2_in = (zr_w > ZRW'(Z_MAX)) ? Z_MAX : zr_w[Z_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (load.ld_s1) begin
         p1_ff     <= p1_in;
         color1_ff <= req_color_bgr;
      end
      if (load.ld_s2) begin
         z2_ff     <= z2_in;
         color2_ff <= color1_ff;
      end
      if (load.ld_s3) begin
         z3_ff     <= z2_ff;
         color3_ff <= color2_ff;
      end
      if (load.ld_s4) begin
         z4_ff     <= z3_ff;
         color4_ff <= color3_ff;
      end
      if (load.ld_s5) begin
         z5_ff     <= z4_ff;
         color5_ff <= color4_ff;
      end
      if (load.ld_s6) begin
         z6_ff     <= z5_ff;
         color6_ff <= color5_ff;
      end
   end

   dpb_lateral #(
      .COORD_BITS (COORD_BITS)
   ) u_lateral_x (
      .clock  (clock),
      .load   (load),
      .coord  (req_col),
      .center (center_x_ff),
      .inv_f  (inv_focal_x_ff),
      .zq     (z2_ff),
      .point  (rsp_point_x)
   );

   dpb_lateral #(
      .COORD_BITS (COORD_BITS)
   ) u_lateral_y (
      .clock  (clock),
      .load   (load),
      .coord  (req_row),
      .center (center_y_ff),
      .inv_f  (inv_focal_y_ff),
      .zq     (z2_ff),
      .point  (rsp_point_y)
   );

   assign req_stall       = !ready[0];
   assign rsp_valid       = valid_ff[NUM_STAGES-1];
   assign rsp_point_z     = z6_ff;
   assign rsp_point_color = color6_ff;

   a_zero_depth_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_depth == '0)) |=> !valid_ff[0])
      else $error("zero-depth pixel entered the pipeline");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled while a stage was free");

   a_held_stage_keeps_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !ready[2]) |=> valid_ff[2])
      else $error("blocked stage lost its word");

   a_reset_empties_pipe: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
